// ===== src/fixed_point_cosine_stream_assert.svh =====
// ----------------------------------------------------------------------------
// Fixed-point cosine stream: assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_COSINE_STREAM_ASSERT_SVH
`define FIXED_POINT_COSINE_STREAM_ASSERT_SVH

// Same-cycle implication.
`define FCS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point cosine stream: package
// Widths, CORDIC constants, arctangent table and shared types.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 4;
    localparam int XY_W     = 33;
    localparam int Z_W      = 32;
    localparam int SUM_W    = 63;
    localparam int T_W      = 48;
    localparam int Q_W      = T_W - 30;

    localparam int CORDIC_STAGES_DEF = 18;
    localparam int MAX_STAGES        = 32;

    // round(2^48 / (2*pi)), split for two narrow multipliers
    localparam logic [45:0] PHASE_SCALE = 46'd44798133900177;
    localparam logic [22:0] PS_HI       = PHASE_SCALE[45:23];
    localparam logic [22:0] PS_LO       = PHASE_SCALE[22:0];

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032875;
    localparam logic signed [Z_W-1:0]  Z_QUARTER = 32'sd1073741824;
    localparam logic signed [Z_W-1:0]  Z_HALF    = 32'sh8000_0000;

    localparam logic signed [T_W-1:0] T_HALF  = 48'sd536870912;
    localparam logic signed [T_W-1:0] T_ROUND = 48'sd1073741823;

    localparam logic signed [SAMPLE_W-1:0] COS_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] COS_MIN = 16'sh8000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [Z_W-1:0] ATAN_TURNS [MAX_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [0:0] {
        REG_INPUT_FRAC  = 1'b0,
        REG_OUTPUT_FRAC = 1'b1
    } fcs_reg_t;

    // Control travelling alongside each pipeline stage
    typedef struct packed {
        logic valid;
        logic neg;
        logic last;
    } fcs_tag_t;

endpackage

// ===== src/fcs_if.sv =====
// ----------------------------------------------------------------------------
// Fixed-point cosine stream: channel interfaces
// Valid/ready channels for the angle samples and the cosine results.
// ----------------------------------------------------------------------------
interface fcs_sample_if
    import fcs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in;

    modport source (output valid, output sample, output last_in, input ready);
    modport sink   (input valid, input sample, input last_in, output ready);
endinterface

interface fcs_result_if
    import fcs_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] cosine;
    logic                       saturated;
    logic                       last_out;

    modport source (output valid, output cosine, output saturated, output last_out,
                    input ready);
    modport sink   (input valid, input cosine, input saturated, input last_out,
                    output ready);
endinterface

// ===== src/fixed_point_cosine_stream.sv =====
// ----------------------------------------------------------------------------
// Fixed-point cosine stream: top level
// Streaming cos(x) of signed fixed-point angles through a CORDIC cell chain.
// ----------------------------------------------------------------------------
// Channels: samples (sink) carries a signed 16-bit angle in radians with
// input_frac_bits fraction bits plus a last flag; results (source) carries
// the cosine scaled by 2^output_frac_bits, a saturation flag and the copied
// last flag. Both move a transaction when valid and ready are high together.
// Configuration: cfg_we with cfg_index 0 writes input_frac_bits, index 1
// writes output_frac_bits (low 4 bits of cfg_data); write only while idle.
// Throughput: one transaction per cycle while results are not stalled. Every
// stage is a register, so the chain of CORDIC_STAGES cells takes a new angle
// each cycle unless a stall holds it. Pipeline: a result passes three phase
// stages, one cell per stage, a scaling stage and the result register.
// Stall: while a result waits unaccepted the whole pipeline holds and
// samples.ready is low; it follows results.ready combinationally.
// Reset: clears every stage valid bit and loads input_frac_bits = 5 and
// output_frac_bits = 7; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_point_cosine_stream
    import fcs_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  fcs_reg_t            cfg_index,
    input  logic [FRAC_W-1:0]   cfg_data,
    fcs_sample_if.sink          samples,
    fcs_result_if.source        results
);

`include "fixed_point_cosine_stream_assert.svh"

    logic [FRAC_W-1:0] in_frac_reg, out_frac_reg;
    logic              advance;

    fcs_tag_t               tag_chain [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] x_chain   [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] y_chain   [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  z_chain   [CORDIC_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frac_reg  <= 4'd5;
            out_frac_reg <= 4'd7;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INPUT_FRAC:  in_frac_reg  <= cfg_data;
                REG_OUTPUT_FRAC: out_frac_reg <= cfg_data;
                default:         in_frac_reg  <= in_frac_reg;
            endcase
        end
    end

    // Hold everything while the result register is full and not taken
    assign advance       = !results.valid || results.ready;
    assign samples.ready = advance;

    fcs_phase u_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .take    (samples.valid),
        .sample  (samples.sample),
        .last_in (samples.last_in),
        .in_frac (in_frac_reg),
        .tag     (tag_chain[0]),
        .z       (z_chain[0])
    );

    assign x_chain[0] = CORDIC_X0;
    assign y_chain[0] = '0;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        fcs_cell #(
            .IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .tag_prev (tag_chain[g]),
            .x_prev   (x_chain[g]),
            .y_prev   (y_chain[g]),
            .z_prev   (z_chain[g]),
            .tag      (tag_chain[g+1]),
            .x        (x_chain[g+1]),
            .y        (y_chain[g+1]),
            .z        (z_chain[g+1])
        );
    end

    fcs_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .tag_prev  (tag_chain[CORDIC_STAGES]),
        .x_prev    (x_chain[CORDIC_STAGES]),
        .out_frac  (out_frac_reg),
        .valid     (results.valid),
        .cosine    (results.cosine),
        .saturated (results.saturated),
        .last_out  (results.last_out)
    );

    `FCS_ASSERT_IMPLY(sat_clip_a, results.valid && results.saturated, (results.cosine == COS_MAX) || (results.cosine == COS_MIN), "saturation flag without a clipped cosine")
    `FCS_ASSERT_IMPLY(stall_block_a, results.valid && !results.ready, !(samples.valid && samples.ready), "sample taken while the result stalls")

endmodule

// ===== src/fcs_phase.sv =====
// ----------------------------------------------------------------------------
// Fixed-point cosine stream: phase front end
// Converts the sample to a 32-bit phase (one turn = 2^32) in three stages
// and folds it into a quarter turn either side of zero.
// ----------------------------------------------------------------------------
module fcs_phase
    import fcs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       take,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last_in,
    input  logic        [FRAC_W-1:0]   in_frac,
    output fcs_tag_t                   tag,
    output logic signed [Z_W-1:0]      z
);

`include "fixed_point_cosine_stream_assert.svh"

    fcs_tag_t                 mul_tag_reg, sum_tag_reg, tag_reg;
    fcs_tag_t                 mul_tag_next, sum_tag_next, tag_next;
    logic signed [39:0]       p_hi_reg, p_lo_reg, p_hi_next, p_lo_next;
    logic        [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic                     neg_next;
    logic        [4:0]        shift;
    logic        [SUM_W-1:0]  round_bit;
    logic signed [Z_W-1:0]    phase;

    assign shift     = 5'(in_frac) + 5'd16;
    assign round_bit = SUM_W'(1) << (shift - 5'd1);

    always_comb
    begin
        p_hi_next = 40'(sample * $signed({1'b0, PS_HI}));
        p_lo_next = 40'(sample * $signed({1'b0, PS_LO}));
        sum_next  = SUM_W'((SUM_W'(p_hi_reg) << 23) + SUM_W'(p_lo_reg) + round_bit);
        phase     = Z_W'(sum_reg >> shift);

        // Past a quarter turn either side: move half a turn toward zero and flip the sign later
        priority if (phase > Z_QUARTER)
        begin
            z_next   = phase - Z_HALF;
            neg_next = 1'b1;
        end
        else if (phase < -Z_QUARTER)
        begin
            z_next   = phase + Z_HALF;
            neg_next = 1'b1;
        end
        else
        begin
            z_next   = phase;
            neg_next = 1'b0;
        end

        mul_tag_next = '{valid: take, neg: 1'b0, last: last_in};
        sum_tag_next = mul_tag_reg;
        tag_next     = '{valid: sum_tag_reg.valid, neg: neg_next, last: sum_tag_reg.last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_tag_reg <= '0;
            sum_tag_reg <= '0;
            tag_reg     <= '0;
        end
        else if (advance)
        begin
            mul_tag_reg <= mul_tag_next;
            sum_tag_reg <= sum_tag_next;
            tag_reg     <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_hi_reg <= p_hi_next;
            p_lo_reg <= p_lo_next;
            sum_reg  <= sum_next;
            z_reg    <= z_next;
        end
    end

    assign tag = tag_reg;
    assign z   = z_reg;

    `FCS_ASSERT_IMPLY(fold_range_a, tag_reg.valid,
        (z_reg <= Z_QUARTER) && (z_reg >= -Z_QUARTER),
        "folded phase outside a quarter turn")

endmodule

// ===== src/fcs_cell.sv =====
// ----------------------------------------------------------------------------
// Fixed-point cosine stream: CORDIC cell
// One rotation-mode micro-rotation by atan(2^-IDX), registered.
// ----------------------------------------------------------------------------
module fcs_cell
    import fcs_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  fcs_tag_t               tag_prev,
    input  logic signed [XY_W-1:0] x_prev,
    input  logic signed [XY_W-1:0] y_prev,
    input  logic signed [Z_W-1:0]  z_prev,
    output fcs_tag_t               tag,
    output logic signed [XY_W-1:0] x,
    output logic signed [XY_W-1:0] y,
    output logic signed [Z_W-1:0]  z
);

    localparam logic signed [Z_W-1:0] ANGLE = $signed(ATAN_TURNS[IDX]);

    fcs_tag_t               tag_reg;
    logic signed [XY_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic signed [XY_W-1:0] dx, dy;

    always_comb
    begin
        dx = y_prev >>> IDX;
        dy = x_prev >>> IDX;
        if (z_prev >= 0)
        begin
            x_next = x_prev - dx;
            y_next = y_prev + dy;
            z_next = z_prev - ANGLE;
        end
        else
        begin
            x_next = x_prev + dx;
            y_next = y_prev - dy;
            z_next = z_prev + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (advance)
        begin
            tag_reg <= tag_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign tag = tag_reg;
    assign x   = x_reg;
    assign y   = y_reg;
    assign z   = z_reg;

endmodule

// ===== src/fcs_scale.sv =====
// ----------------------------------------------------------------------------
// Fixed-point cosine stream: output scaling
// Applies the fold sign, scales by 2^output_frac_bits, adds half an LSB,
// truncates toward zero, saturates and holds the result register.
// ----------------------------------------------------------------------------
module fcs_scale
    import fcs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  fcs_tag_t                   tag_prev,
    input  logic signed [XY_W-1:0]     x_prev,
    input  logic        [FRAC_W-1:0]   out_frac,
    output logic                       valid,
    output logic signed [SAMPLE_W-1:0] cosine,
    output logic                       saturated,
    output logic                       last_out
);

`include "fixed_point_cosine_stream_assert.svh"

    fcs_tag_t                   t_tag_reg;
    logic signed [T_W-1:0]      t_reg, t_next;
    logic signed [XY_W-1:0]     x_signed;
    logic signed [T_W-1:0]      t_adj;
    logic signed [Q_W-1:0]      q;
    logic                       valid_reg, last_reg, sat_reg, sat_next;
    logic signed [SAMPLE_W-1:0] cos_reg, cos_next;

    always_comb
    begin
        x_signed = tag_prev.neg ? -x_prev : x_prev;
        t_next   = (T_W'(x_signed) <<< out_frac) + T_HALF;

        // Truncate toward zero: bias negative values before the floor shift
        t_adj = (t_reg < 0) ? t_reg + T_ROUND : t_reg;
        q     = Q_W'(t_adj >>> 30);

        priority if (q > Q_W'(COS_MAX))
        begin
            cos_next = COS_MAX;
            sat_next = 1'b1;
        end
        else if (q < Q_W'(COS_MIN))
        begin
            cos_next = COS_MIN;
            sat_next = 1'b1;
        end
        else
        begin
            cos_next = SAMPLE_W'(q);
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_tag_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            t_tag_reg <= tag_prev;
            valid_reg <= t_tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_reg    <= t_next;
            cos_reg  <= cos_next;
            sat_reg  <= sat_next;
            last_reg <= t_tag_reg.last;
        end
    end

    assign valid     = valid_reg;
    assign cosine    = cos_reg;
    assign saturated = sat_reg;
    assign last_out  = last_reg;

    `FCS_ASSERT_NEXT(scale_move_a, t_tag_reg.valid && advance, valid_reg, "item lost between scaling and result register")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Fixed-point cosine stream: testbench
// Sends signed angle samples through the valid/ready input channel and checks
// each returned cosine, saturation flag and last flag against a CORDIC
// predictor kept in the bench. It steps through several fraction-bit settings,
// the extremes among them, with random gaps on the sender and random stalls
// on the receiver.
// ----------------------------------------------------------------------------
module tb_top;
    import fcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      CORDIC_STEPS = 18;
    localparam int      CYCLE_LIMIT  = 400000;
    localparam int      PHASE_ITEMS  = 230;
    localparam longint  TURN_SCALE   = 64'sd44798133900177;  // 2^48 / (2*pi)
    localparam longint  GAIN_X0      = 64'sd652032875;
    localparam longint  QUARTER_TURN = 64'sd1073741824;
    localparam longint  HALF_TURN    = 64'sd2147483648;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam longint ATAN_STEP [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } angle_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] cosine;
        logic                       saturated;
        logic                       last;
    } cos_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    fcs_reg_t          cfg_index;
    logic [FRAC_W-1:0] cfg_data;

    fcs_sample_if angle_ch ();
    fcs_result_if cos_ch ();

    angle_item_t       angle_q [$];
    cos_result_t       cos_expect_q [$];
    logic [FRAC_W-1:0] in_frac_cfg  = 4'd5;
    logic [FRAC_W-1:0] out_frac_cfg = 4'd7;
    int                send_gap_max   = 0;
    int                recv_stall_max = 0;
    int                send_wait;
    int                recv_wait;
    int                mismatch_count = 0;
    int                cycle_count    = 0;

    fixed_point_cosine_stream #(
        .CORDIC_STAGES (CORDIC_STEPS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (angle_ch.sink),
        .results   (cos_ch.source)
    );

    always #4 clk = ~clk;

    function automatic cos_result_t predict_cosine(logic signed [SAMPLE_W-1:0] angle,
                                                   logic last,
                                                   logic [FRAC_W-1:0] in_fb,
                                                   logic [FRAC_W-1:0] out_fb);
        longint      prod;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        longint      t;
        longint      q;
        logic [31:0] phase;
        bit          flip;
        int          shamt;
        int          steps;
        cos_result_t r;
        shamt = int'(in_fb) + 16;
        prod  = longint'(angle) * TURN_SCALE + (64'sd1 <<< (shamt - 1));
        prod  = prod >>> shamt;
        phase = prod[31:0];
        z     = longint'($signed(phase));
        flip  = 1'b0;
        // fold into the right half-plane, negate the cosine afterwards
        if (z > QUARTER_TURN)
        begin
            z    = z - HALF_TURN;
            flip = 1'b1;
        end
        else if (z < -QUARTER_TURN)
        begin
            z    = z + HALF_TURN;
            flip = 1'b1;
        end
        steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
        x = GAIN_X0;
        y = 0;
        for (int i = 0; i < steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        if (flip)
            x = -x;
        t = x * (64'sd1 <<< out_fb) + (64'sd1 <<< 29);
        q = (t >= 0) ? (t >>> 30) : -((-t) >>> 30);
        r.saturated = (q > 32767) || (q < -32768);
        if (q > 32767)
            r.cosine = 16'sh7FFF;
        else if (q < -32768)
            r.cosine = 16'sh8000;
        else
            r.cosine = q[15:0];
        r.last = last;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_angle();
        int v;
        case ($urandom_range(0, 3))
            0, 1: v = int'($urandom);
            2:    v = int'($urandom_range(0, 200)) - 100;
            default: v = int'($urandom_range(0, 8191)) - 4096;
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic queue_angle(logic [SAMPLE_W-1:0] angle, logic last);
        angle_item_t it;
        it.sample = angle;
        it.last   = last;
        angle_q.push_back(it);
    endtask

    // hold until every queued angle is sent and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (angle_q.size() != 0 || angle_ch.valid || cos_expect_q.size() != 0);
    endtask

    task automatic write_reg(fcs_reg_t idx, logic [FRAC_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_frac(logic [FRAC_W-1:0] in_fb, logic [FRAC_W-1:0] out_fb);
        write_reg(REG_INPUT_FRAC, in_fb);
        write_reg(REG_OUTPUT_FRAC, out_fb);
        in_frac_cfg  = in_fb;
        out_frac_cfg = out_fb;
        @(negedge clk);
    endtask

    // sender: offers one transaction at a time, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        angle_item_t nxt;
        if (!rst_n)
        begin
            angle_ch.valid   <= 1'b0;
            angle_ch.sample  <= '0;
            angle_ch.last_in <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (angle_ch.valid && angle_ch.ready)
                cos_expect_q.push_back(predict_cosine(angle_ch.sample, angle_ch.last_in,
                                                      in_frac_cfg, out_frac_cfg));
            if (!angle_ch.valid || angle_ch.ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    angle_ch.valid <= 1'b0;
                end
                else if (angle_q.size() > 0)
                begin
                    nxt = angle_q.pop_front();
                    angle_ch.valid   <= 1'b1;
                    angle_ch.sample  <= nxt.sample;
                    angle_ch.last_in <= nxt.last;
                    send_wait = $urandom_range(0, send_gap_max);
                end
                else
                begin
                    angle_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each result, then stall at random
    always @(posedge clk or negedge rst_n)
    begin
        cos_result_t exp_res;
        if (!rst_n)
        begin
            cos_ch.ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (cos_ch.valid && cos_ch.ready)
            begin
                if (cos_expect_q.size() == 0)
                begin
                    $error("unexpected result transaction: cosine %0d", cos_ch.cosine);
                    mismatch_count++;
                end
                else
                begin
                    exp_res = cos_expect_q.pop_front();
                    if (cos_ch.cosine !== exp_res.cosine)
                    begin
                        $error("cosine: expected %0d, actual %0d",
                               exp_res.cosine, cos_ch.cosine);
                        mismatch_count++;
                    end
                    if (cos_ch.saturated !== exp_res.saturated)
                    begin
                        $error("saturated: expected %0b, actual %0b",
                               exp_res.saturated, cos_ch.saturated);
                        mismatch_count++;
                    end
                    if (cos_ch.last_out !== exp_res.last)
                    begin
                        $error("last_out: expected %0b, actual %0b",
                               exp_res.last, cos_ch.last_out);
                        mismatch_count++;
                    end
                end
                recv_wait = $urandom_range(0, recv_stall_max);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                cos_ch.ready <= 1'b0;
            end
            else
            begin
                cos_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [FRAC_W-1:0] in_fb;
        logic [FRAC_W-1:0] out_fb;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_INPUT_FRAC;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero, extremes, quarter, half and full turn
        queue_angle(16'sd0, 1'b0);
        queue_angle(16'sd1, 1'b1);
        queue_angle(-16'sd1, 1'b0);
        queue_angle(16'sh7FFF, 1'b1);
        queue_angle(16'sh8000, 1'b0);
        queue_angle(16'sd50, 1'b0);
        queue_angle(-16'sd50, 1'b1);
        queue_angle(16'sd101, 1'b0);
        queue_angle(16'sd201, 1'b0);
        queue_angle(16'sh5555, 1'b1);
        queue_angle(16'shAAAA, 1'b0);
        wait_drained();

        // full scale output: cos near one clips to the top
        set_frac(4'd15, 4'd15);
        queue_angle(16'sd0, 1'b1);
        queue_angle(16'sd1, 1'b0);
        queue_angle(16'sh7FFF, 1'b0);
        queue_angle(16'sh8000, 1'b1);
        wait_drained();

        set_frac(4'd0, 4'd0);
        queue_angle(16'sd0, 1'b0);
        queue_angle(16'sd3, 1'b1);
        queue_angle(16'sh7FFF, 1'b0);
        wait_drained();

        set_frac(4'd0, 4'd15);
        queue_angle(16'sd3, 1'b0);
        queue_angle(16'sh8000, 1'b1);
        wait_drained();

        set_frac(4'd15, 4'd0);
        queue_angle(16'sd0, 1'b0);
        queue_angle(-16'sd1, 1'b1);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    in_fb  = 4'd0;
                    out_fb = 4'd0;
                end
                1:
                begin
                    in_fb  = 4'd15;
                    out_fb = 4'd15;
                end
                2:
                begin
                    in_fb  = 4'd5;
                    out_fb = 4'd7;
                end
                3:
                begin
                    in_fb  = 4'd15;
                    out_fb = 4'd0;
                end
                default:
                begin
                    in_fb  = 4'($urandom);
                    out_fb = 4'($urandom);
                end
            endcase
            case (p % 3)
                0:
                begin
                    send_gap_max   = 0;
                    recv_stall_max = 0;
                end
                1:
                begin
                    send_gap_max   = 15;
                    recv_stall_max = 15;
                end
                default:
                begin
                    send_gap_max   = 3;
                    recv_stall_max = 15;
                end
            endcase
            set_frac(in_fb, out_fb);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_angle(draw_angle(), 1'($urandom));
            wait_drained();
        end

        // let any stray result show up
        repeat (CORDIC_STEPS + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== fixed_point_cosine_stream.f =====
+incdir+src
src/fcs_pkg.sv
src/fcs_if.sv
src/fcs_phase.sv
src/fcs_cell.sv
src/fcs_scale.sv
src/fixed_point_cosine_stream.sv
dv/tb_top.sv
